@@ rtl/ae_pkg.sv @@
// shared types, constants and table functions for the auto-exposure block
package ae_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] ONE_Q30   = 32'd1 << 30;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXPOSURE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD  = 3'd5;

    typedef struct packed {
        logic signed [47:0] log_sum;
        logic [31:0]        lum_min;
        logic [31:0]        lum_max;
    } in_t;

    typedef struct packed {
        logic [31:0] exposure;
        logic [31:0] target_exposure;
    } out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_LM_MUL,
        OP_LM_SET,
        OP_NORM,
        OP_SQ_MUL,
        OP_SQ_SET,
        OP_LOG_STORE,
        OP_F_START,
        OP_F_SET,
        OP_EXP_MUL,
        OP_EXP_SET,
        OP_KEY_MUL,
        OP_TGT,
        OP_ADAPT_MUL,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              sel;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic norm_done;
    } status_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'd1 << 62;
        rem  = v;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q2.30, each root truncated from the previous one
    function automatic logic [31:0] exp2_root(input int k);
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int i = 0; i < k; i++) begin
            c = isqrt64(c << 30);
        end
        return c[31:0];
    endfunction

endpackage

@@ rtl/auto_exposure_adapter_top.sv @@
// Auto-exposure adapter: one frame statistics item in, one exposure item out.
// The work is set by the two bit-serial divides, the two leading-one searches and
// the log/exp digit loops on one shared multiplier. One item is in work at a time,
// and a stalled output holds it back.
// Synchronous active-low reset restores the default registers, exposure 1.0.
module auto_exposure_adapter_top #(
    parameter int FRAC_BITS = ae_pkg::FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ae_pkg::in_t                  s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ae_pkg::out_t                 m_item,
    input  logic                         cfg_wr_en,
    input  logic [ae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ae_pkg::CFG_W-1:0]     cfg_wdata
);
    import ae_pkg::*;

    cmd_t    cmd;
    status_t status;

    ae_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ae_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_item    (s_item),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );
endmodule

@@ rtl/ae_div.sv @@
// restoring divider, one quotient bit per cycle
module ae_div #(
    parameter int DIVD_W = 48,
    parameter int DIVS_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              busy,
    output logic [DIVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVD_W-1:0] quot_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quot_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            quot_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg  <= fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            quot_reg <= {quot_reg[DIVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;
endmodule

@@ rtl/ae_dp.sv @@
// datapath: config registers, shared multiplier, divider, log/exp registers
module ae_dp #(
    parameter int FRAC_BITS = ae_pkg::FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ae_pkg::cmd_t                 cmd,
    output ae_pkg::status_t              status,
    input  ae_pkg::in_t                  s_item,
    output ae_pkg::out_t                 m_item,
    input  logic                         cfg_wr_en,
    input  logic [ae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ae_pkg::CFG_W-1:0]     cfg_wdata
);
    import ae_pkg::*;

    localparam int FB     = FRAC_BITS;
    localparam int DIVD_W = (2 * FB + 10 > 48) ? 2 * FB + 10 : 48;
    localparam int DIVS_W = 32;
    localparam int LIM_W  = FB + 7;
    localparam int LOG_W  = FB + 7;
    localparam int LM_W   = FB + 8;
    localparam int NUM_W  = FB + 10;
    localparam int F_W    = FB + 8;
    localparam int E_W    = FB + 10;
    localparam int EO_W   = FB + 8;

    localparam logic [DIVD_W-1:0]     LIM_D = DIVD_W'(64) << FB;
    localparam logic signed [E_W-1:0] E_LIM = E_W'(64) <<< FB;
    localparam logic [EO_W-1:0]       E_OFS = EO_W'(128) << FB;

    // config and carried state
    logic [12:0] width_reg, height_reg;
    logic [19:0] key_reg;
    logic [16:0] rate_reg;
    logic [31:0] minexp_reg;
    logic [7:0]  period_reg;
    logic [31:0] prev_reg, base_reg;
    logic [7:0]  phase_reg;

    // working registers
    logic [31:0]             lmin_reg, lmax_reg;
    logic                    neg_reg;
    logic signed [LM_W-1:0]  lm_reg;
    logic [32:0]             x_reg;
    logic [5:0]              p_reg;
    logic [30:0]             m_reg;
    logic [FB-1:0]           frac_reg;
    logic signed [LOG_W-1:0] a_reg, b_reg;
    logic                    den_zero_reg, fneg_reg;
    logic [7:0]              eohi_reg;
    logic [FB-1:0]           fr_reg;
    logic [31:0]             r_reg;
    logic [31:0]             target_reg;
    logic [31:0]             dmag_reg;
    logic                    dneg_reg;
    logic [63:0]             mul_reg;
    out_t                    out_reg;

    // constant table of roots
    logic [31:0] root_tab [2**STEP_W];
    for (genvar gi = 0; gi < 2**STEP_W; gi++) begin : g_root
        if (gi < FB) begin : g_on
            assign root_tab[gi] = exp2_root(gi + 1);
        end else begin : g_off
            assign root_tab[gi] = '0;
        end
    end

    // divider
    logic              div_start, div_busy;
    logic [DIVD_W-1:0] div_dividend, quot;
    logic [DIVS_W-1:0] div_divisor;

    ae_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (DIVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    // input magnitude and divisor
    logic [47:0] raw_mag;
    logic [12:0] wv, hv;
    logic [25:0] wh;
    assign raw_mag = s_item.log_sum[47] ? 48'(-s_item.log_sum) : 48'(s_item.log_sum);
    assign wv      = (width_reg == '0) ? 13'd1 : width_reg;
    assign hv      = (height_reg == '0) ? 13'd1 : height_reg;
    assign wh      = 26'(wv) * 26'(hv);

    // ratio numerator and denominator
    logic signed [NUM_W-1:0] num_v;
    logic signed [LOG_W:0]   den_v;
    logic [NUM_W-1:0]        un;
    logic [LOG_W:0]          ud;
    assign num_v = (NUM_W'(lm_reg) <<< 1) - NUM_W'(a_reg) - NUM_W'(b_reg);
    assign den_v = (LOG_W + 1)'(b_reg) - (LOG_W + 1)'(a_reg);
    assign un    = num_v[NUM_W-1] ? NUM_W'(-num_v) : NUM_W'(num_v);
    assign ud    = den_v[LOG_W] ? (LOG_W + 1)'(-den_v) : (LOG_W + 1)'(den_v);

    assign div_start    = (cmd.op == OP_LOAD) || (cmd.op == OP_F_START);
    assign div_dividend = (cmd.op == OP_LOAD) ? DIVD_W'(raw_mag) : (DIVD_W'(un) << FB);
    assign div_divisor  = (cmd.op == OP_LOAD) ? DIVS_W'(wh) : DIVS_W'(ud);

    // clamped quotient
    logic [LIM_W-1:0] qclamp;
    assign qclamp = (quot > LIM_D) ? LIM_W'(LIM_D) : quot[LIM_W-1:0];

    // log2 mean
    logic [LM_W-2:0]        lmmag;
    logic signed [LM_W-1:0] lm_v;
    assign lmmag = mul_reg[30 +: LM_W-1];
    assign lm_v  = neg_reg ? -signed'({1'b0, lmmag}) : signed'({1'b0, lmmag});

    // log digit step
    logic [31:0]             sq;
    logic signed [6:0]       pexp;
    logic signed [LOG_W-1:0] log_v;
    assign sq    = mul_reg[61:30];
    assign pexp  = signed'(7'(p_reg) - 7'(FB));
    assign log_v = signed'({pexp, frac_reg});

    // exponent split
    logic [LIM_W-1:0]       fq;
    logic signed [F_W-1:0]  f_v;
    logic signed [E_W-1:0]  e_raw, e_cl;
    logic [EO_W-1:0]        eo;
    assign fq    = den_zero_reg ? '0 : qclamp;
    assign f_v   = fneg_reg ? -signed'(F_W'(fq)) : signed'(F_W'(fq));
    assign e_raw = (E_W'(f_v) <<< 1) - E_W'(lm_reg);
    assign e_cl  = (e_raw > E_LIM) ? E_LIM : ((e_raw < -E_LIM) ? -E_LIM : e_raw);
    assign eo    = EO_W'(unsigned'(e_cl)) + E_OFS;

    logic [FB-1:0] fr_sh;
    assign fr_sh = fr_reg << cmd.step;

    // target and smoothing
    logic [50:0] prod;
    logic [7:0]  sh8;
    logic [50:0] shifted;
    logic [31:0] tgt_raw, tgt, base_eff, avg;
    logic [32:0] avg_sum;
    logic [32:0] delta;
    assign prod     = mul_reg[50:0];
    assign sh8      = 8'd158 - eohi_reg;
    assign shifted  = prod >> sh8[5:0];
    always_comb begin
        if (prod == '0)                tgt_raw = '0;
        else if (eohi_reg >= 8'd158)   tgt_raw = '1;
        else if (eohi_reg <= 8'd94)    tgt_raw = '0;
        else if (shifted[50:32] != '0) tgt_raw = '1;
        else                           tgt_raw = shifted[31:0];
    end
    assign tgt      = (tgt_raw < minexp_reg) ? minexp_reg : tgt_raw;
    assign base_eff = (phase_reg == '0) ? tgt : base_reg;
    assign avg_sum  = 33'(tgt) + 33'(base_eff);
    assign avg      = avg_sum[32:1];
    assign delta    = {1'b0, avg} - {1'b0, prev_reg};

    logic [32:0] smag;
    logic [33:0] up_sum;
    logic [31:0] next_exp;
    logic [7:0]  period;
    logic [8:0]  phase_inc;
    assign smag   = mul_reg[48:16];
    assign up_sum = 34'(prev_reg) + 34'(smag);
    always_comb begin
        if (dneg_reg) begin
            next_exp = (smag > 33'(prev_reg)) ? '0 : 32'(33'(prev_reg) - smag);
        end else begin
            next_exp = (up_sum[33:32] != '0) ? '1 : up_sum[31:0];
        end
    end
    assign period    = (period_reg == '0) ? 8'd1 : period_reg;
    assign phase_inc = 9'(phase_reg) + 9'd1;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    logic        mul_en;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_LM_MUL: begin
                mul_a = 32'(qclamp);
                mul_b = 32'(LOG2E_Q30);
            end
            OP_SQ_MUL: begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            OP_EXP_MUL: begin
                mul_a = r_reg;
                mul_b = root_tab[cmd.step];
            end
            OP_KEY_MUL: begin
                mul_a = 32'(key_reg);
                mul_b = r_reg;
            end
            OP_ADAPT_MUL: begin
                mul_a = dmag_reg;
                mul_b = 32'(rate_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product holds while the result waits for the output
    assign mul_en = (cmd.op == OP_LM_MUL) || (cmd.op == OP_SQ_MUL) ||
                    (cmd.op == OP_EXP_MUL) || (cmd.op == OP_KEY_MUL) ||
                    (cmd.op == OP_ADAPT_MUL);

    always_ff @(posedge aclk) begin
        if (mul_en) mul_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd512;
            height_reg <= 13'd512;
            key_reg    <= 20'd78643;
            rate_reg   <= 17'd6554;
            minexp_reg <= 32'd6554;
            period_reg <= 8'd25;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata[12:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_wdata[12:0];
                CFG_KEY_SCALE:    key_reg    <= cfg_wdata[19:0];
                CFG_ADAPT_RATE:   rate_reg   <= cfg_wdata[16:0];
                CFG_MIN_EXPOSURE: minexp_reg <= cfg_wdata[31:0];
                CFG_BASE_PERIOD:  period_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 32'(1) << FB;
            base_reg  <= 32'(1) << FB;
            phase_reg <= '0;
        end else if (cmd.op == OP_TGT) begin
            base_reg <= base_eff;
        end else if (cmd.op == OP_OUT) begin
            prev_reg  <= next_exp;
            phase_reg <= (phase_inc >= 9'(period)) ? '0 : phase_inc[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                lmin_reg <= s_item.lum_min;
                lmax_reg <= s_item.lum_max;
                neg_reg  <= s_item.log_sum[47];
            end
            OP_LM_SET: begin
                lm_reg <= lm_v;
                x_reg  <= 33'(lmin_reg) + 33'd1;
                p_reg  <= 6'd32;
            end
            OP_NORM: begin
                // shift until the leading one reaches the top bit
                if (x_reg[32]) begin
                    m_reg    <= x_reg[32:2];
                    frac_reg <= '0;
                end else begin
                    x_reg <= {x_reg[31:0], 1'b0};
                    p_reg <= p_reg - 6'd1;
                end
            end
            OP_SQ_SET: begin
                frac_reg <= {frac_reg[FB-2:0], sq[31]};
                m_reg    <= sq[31] ? sq[31:1] : sq[30:0];
            end
            OP_LOG_STORE: begin
                if (!cmd.sel) begin
                    a_reg <= log_v;
                    x_reg <= 33'(lmax_reg) + 33'd1;
                    p_reg <= 6'd32;
                end else begin
                    b_reg <= log_v;
                end
            end
            OP_F_START: begin
                den_zero_reg <= (den_v == '0);
                fneg_reg     <= num_v[NUM_W-1] ^ den_v[LOG_W];
            end
            OP_F_SET: begin
                eohi_reg <= eo[FB +: 8];
                fr_reg   <= eo[FB-1:0];
                r_reg    <= ONE_Q30;
            end
            OP_EXP_SET: begin
                if (fr_sh[FB-1]) r_reg <= mul_reg[61:30];
            end
            OP_TGT: begin
                target_reg <= tgt;
                dneg_reg   <= delta[32];
                dmag_reg   <= delta[32] ? 32'(-delta) : delta[31:0];
            end
            OP_OUT: begin
                out_reg.exposure        <= next_exp;
                out_reg.target_exposure <= target_reg;
            end
            default: ;
        endcase
    end

    assign status.div_busy  = div_busy;
    assign status.norm_done = x_reg[32];
    assign m_item           = out_reg;
endmodule

@@ rtl/ae_ctrl.sv @@
// controller: sequences one frame item through the datapath
module ae_ctrl #(
    parameter int FRAC_BITS = ae_pkg::FRAC_BITS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output ae_pkg::cmd_t    cmd,
    input  ae_pkg::status_t status
);
    import ae_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV1, S_LM_MUL, S_LM_SET, S_NORM, S_SQ_MUL, S_SQ_SET, S_STORE,
        S_F_START, S_F_WAIT, S_F_SET, S_EXP_MUL, S_EXP_SET, S_KEY_MUL, S_TGT,
        S_ADAPT, S_OUT
    } state_t;

    state_t            state_reg;
    logic              m_valid_reg;
    logic              sel_reg;
    logic [STEP_W-1:0] step_reg;
    logic              last_step;
    logic              room;

    assign last_step = step_reg == STEP_W'(FRAC_BITS - 1);
    assign room      = !m_valid_reg || m_ready;

    always_comb begin
        cmd.op   = OP_NOP;
        cmd.sel  = sel_reg;
        cmd.step = step_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) cmd.op = OP_LOAD;
            S_DIV1:    cmd.op = OP_NOP;
            S_LM_MUL:  cmd.op = OP_LM_MUL;
            S_LM_SET:  cmd.op = OP_LM_SET;
            S_NORM:    cmd.op = OP_NORM;
            S_SQ_MUL:  cmd.op = OP_SQ_MUL;
            S_SQ_SET:  cmd.op = OP_SQ_SET;
            S_STORE:   cmd.op = OP_LOG_STORE;
            S_F_START: cmd.op = OP_F_START;
            S_F_WAIT:  cmd.op = OP_NOP;
            S_F_SET:   cmd.op = OP_F_SET;
            S_EXP_MUL: cmd.op = OP_EXP_MUL;
            S_EXP_SET: cmd.op = OP_EXP_SET;
            S_KEY_MUL: cmd.op = OP_KEY_MUL;
            S_TGT:     cmd.op = OP_TGT;
            S_ADAPT:   cmd.op = OP_ADAPT_MUL;
            S_OUT:     if (room) cmd.op = OP_OUT;
            default:   cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (state_reg == S_OUT && room) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:   if (s_valid) state_reg <= S_DIV1;
                S_DIV1:   if (!status.div_busy) state_reg <= S_LM_MUL;
                S_LM_MUL: state_reg <= S_LM_SET;
                S_LM_SET: begin
                    sel_reg   <= 1'b0;
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    if (status.norm_done) begin
                        step_reg  <= '0;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL: state_reg <= S_SQ_SET;
                S_SQ_SET: begin
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= last_step ? S_STORE : S_SQ_MUL;
                end
                S_STORE: begin
                    // first pass holds the minimum, second the maximum
                    sel_reg   <= 1'b1;
                    state_reg <= sel_reg ? S_F_START : S_NORM;
                end
                S_F_START: state_reg <= S_F_WAIT;
                S_F_WAIT:  if (!status.div_busy) state_reg <= S_F_SET;
                S_F_SET: begin
                    step_reg  <= '0;
                    state_reg <= S_EXP_MUL;
                end
                S_EXP_MUL: state_reg <= S_EXP_SET;
                S_EXP_SET: begin
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= last_step ? S_KEY_MUL : S_EXP_MUL;
                end
                S_KEY_MUL: state_reg <= S_TGT;
                S_TGT:     state_reg <= S_ADAPT;
                S_ADAPT:   state_reg <= S_OUT;
                S_OUT: begin
                    if (room) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
endmodule

@@ sim/tb_auto_exposure_adapter_top.sv @@
// testbench for the auto-exposure adapter: directed and random frame statistics checked by a scoreboard
`timescale 1ns / 1ps

module tb_auto_exposure_adapter_top;
    import ae_pkg::*;

    localparam longint LIM = longint'(64) << FRAC_BITS;
    localparam longint unsigned LOG2E = 64'd1549082005;
    localparam longint unsigned Q30 = 64'd1 << 30;

    class exposure_scoreboard;
        logic [12:0] frame_width, frame_height;
        logic [19:0] key_scale;
        logic [16:0] adapt_rate;
        logic [31:0] min_exposure;
        logic [7:0]  base_period;
        logic [31:0] prev_exposure, base_exposure;
        logic [7:0]  frame_phase;
        longint unsigned roots[FRAC_BITS+1];
        out_t        expected_q[$];
        int          errors;

        function new();
            longint unsigned c;
            c = 2 * Q30;
            for (int k = 1; k <= FRAC_BITS; k++) begin
                c = int_sqrt(c << 30);
                roots[k] = c;
            end
            frame_width = 512; frame_height = 512;
            key_scale = 78643; adapt_rate = 6554;
            min_exposure = 6554; base_period = 25;
            prev_exposure = 32'd1 << FRAC_BITS;
            base_exposure = 32'd1 << FRAC_BITS;
            frame_phase = 0;
            errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // log2 of v minus FRAC_BITS, in Q with FRAC_BITS fraction bits, v from 1 to 2^32
        function longint log2_fix(longint unsigned v);
            int p;
            longint unsigned m, frac;
            p = 0;
            frac = 0;
            while (p < 63 && (v >> (p + 1)) != 0) p++;
            m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
            for (int k = 0; k < FRAC_BITS; k++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= 2 * Q30) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return longint'(p - FRAC_BITS) * (longint'(1) << FRAC_BITS) + longint'(frac);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  frame_width = val[12:0];
                CFG_FRAME_HEIGHT: frame_height = val[12:0];
                CFG_KEY_SCALE:    key_scale = val[19:0];
                CFG_ADAPT_RATE:   adapt_rate = val[16:0];
                CFG_MIN_EXPOSURE: min_exposure = val;
                CFG_BASE_PERIOD:  base_period = val[7:0];
                default: ;
            endcase
        endfunction

        function void note_frame(in_t x);
            logic [47:0] raw;
            logic neg;
            longint unsigned mag, w, h, lmmag, un, ud, q, fr, pw, prod, target, avg, smag;
            longint lm, a, b, num, den, f, e, eo, ip, delta, next, s;
            int unsigned period;
            out_t r;
            raw = x.log_sum;
            neg = raw[47];
            mag = neg ? ((~{16'd0, raw} + 1) & 64'hFFFF_FFFF_FFFF) : {16'd0, raw};
            w = frame_width ? frame_width : 1;
            h = frame_height ? frame_height : 1;
            mag = mag / (w * h);
            if (mag > longint'(LIM)) mag = LIM;
            lmmag = (mag * LOG2E) >> 30;
            lm = neg ? -longint'(lmmag) : longint'(lmmag);
            a = log2_fix(longint'(x.lum_min) + 1);
            b = log2_fix(longint'(x.lum_max) + 1);
            den = b - a;
            num = 2 * lm - a - b;
            if (den == 0) begin
                f = 0;
            end else begin
                un = (num < 0) ? -num : num;
                ud = (den < 0) ? -den : den;
                q = (un << FRAC_BITS) / ud;
                f = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
            end
            if (f > LIM) f = LIM;
            if (f < -LIM) f = -LIM;
            e = 2 * f - lm;
            if (e > LIM) e = LIM;
            if (e < -LIM) e = -LIM;
            eo = e + (longint'(128) << FRAC_BITS);
            ip = (eo >> FRAC_BITS) - 128;
            fr = eo & ((longint'(1) << FRAC_BITS) - 1);
            pw = Q30;
            for (int k = 1; k <= FRAC_BITS; k++)
                if ((fr >> (FRAC_BITS - k)) & 1) pw = (pw * roots[k]) >> 30;
            prod = longint'(key_scale) * pw;
            if (prod == 0) begin
                target = 0;
            end else if (ip >= 30) begin
                target = 64'hFFFF_FFFF;
            end else begin
                s = 30 - ip;
                target = (s >= 64) ? 0 : (prod >> s);
                if (target > 64'hFFFF_FFFF) target = 64'hFFFF_FFFF;
            end
            if (target < min_exposure) target = min_exposure;
            if (frame_phase == 0) base_exposure = target[31:0];
            avg = (target + base_exposure) >> 1;
            delta = longint'(avg) - longint'(prev_exposure);
            smag = (longint'(delta < 0 ? -delta : delta) * adapt_rate) >> 16;
            next = longint'(prev_exposure) + (delta < 0 ? -longint'(smag) : longint'(smag));
            if (next < 0) next = 0;
            if (next > 64'hFFFF_FFFF) next = 64'hFFFF_FFFF;
            prev_exposure = next[31:0];
            period = base_period ? base_period : 1;
            frame_phase = (frame_phase + 1 >= period) ? 8'd0 : frame_phase + 8'd1;
            r.exposure = prev_exposure;
            r.target_exposure = target[31:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0) begin
                $error("exposure item with none expected: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.exposure !== want.exposure) begin
                $error("exposure: expected %h, got %h", want.exposure, got.exposure);
                errors++;
            end
            if (got.target_exposure !== want.target_exposure) begin
                $error("target_exposure: expected %h, got %h",
                       want.target_exposure, got.target_exposure);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_item = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_item;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;

    exposure_scoreboard sb = new();
    int results_seen = 0;
    bit started = 0;

    always #5 aclk = ~aclk;

    auto_exposure_adapter_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_frame(s_item);
            if (m_valid && m_ready) begin
                sb.check_result(m_item);
                results_seen++;
            end
        end
    end

    // result side: random stalls per item, one long hold-off to back up the input
    initial begin
        wait (started);
        forever begin
            @(negedge aclk);
            if (results_seen == 40) begin
                m_ready <= 0;
                repeat (3000) @(negedge aclk);
            end else begin
                int gap;
                gap = $urandom_range(0, 3);
                if (gap > 0) begin
                    m_ready <= 0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_frame(in_t x);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_item <= x;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic drain();
        s_valid <= 0;
        wait (sb.expected_q.size() == 0);
        repeat (10) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_lum();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic in_t rand_frame();
        in_t x;
        longint mean;
        longint unsigned w, h;
        w = sb.frame_width ? sb.frame_width : 1;
        h = sb.frame_height ? sb.frame_height : 1;
        if ($urandom_range(0, 9) == 0) begin
            x.log_sum = 48'({$urandom, $urandom});
        end else begin
            mean = longint'($urandom_range(0, 24 << FRAC_BITS)) - (longint'(12) << FRAC_BITS);
            x.log_sum = 48'(mean * longint'(w * h) + $urandom_range(0, 255));
        end
        x.lum_min = rand_lum();
        x.lum_max = rand_lum();
        case ($urandom_range(0, 7))
            0: x.lum_max = x.lum_min;
            1, 2, 3: if (x.lum_min > x.lum_max) {x.lum_min, x.lum_max} = {x.lum_max, x.lum_min};
            default: ;
        endcase
        return x;
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'h1FFF;
            default: return 13'($urandom_range(1, 64));
        endcase
    endfunction

    in_t d;
    logic [CFG_W-1:0] rv;

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        started = 1;
        @(negedge aclk);

        // directed and random frames under the reset settings
        for (int i = 0; i < 20; i++) begin
            d = '{log_sum: 48'sd0, lum_min: 32'd65536, lum_max: 32'd65536};
            case (i)
                0: d.log_sum = 48'h7FFF_FFFF_FFFF;
                1: d.log_sum = 48'h8000_0000_0000;
                2: d.log_sum = 48'hFFFF_FFFF_FFFF;
                3: begin d.lum_min = 0; d.lum_max = 32'hFFFF_FFFF; end
                4: begin d.lum_min = 32'hFFFF_FFFF; d.lum_max = 0; end
                5: begin d.lum_min = 0; d.lum_max = 0; end
                6: begin d.lum_min = 32'hFFFF_FFFF; d.lum_max = 32'hFFFF_FFFF; end
                7: begin d.log_sum = -48'sd1 <<< 30; d.lum_min = 100; d.lum_max = 32'h100000; end
                8: begin d.log_sum = 48'sd1 << 30; d.lum_min = 100; d.lum_max = 32'h100000; end
                default: d = rand_frame();
            endcase
            send_frame(d);
        end
        drain();

        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_FRAME_WIDTH, CFG_W'(pick_dim()));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(pick_dim()));
            case (p % 3)
                0: rv = 0;
                1: rv = 32'hFFFFF;
                default: rv = $urandom_range(0, 20'hFFFFF);
            endcase
            write_reg(CFG_KEY_SCALE, rv);
            case (p % 4)
                0: rv = 65536;
                1: rv = 32'h1FFFF;
                2: rv = 0;
                default: rv = $urandom_range(1, 65536);
            endcase
            write_reg(CFG_ADAPT_RATE, rv);
            case (p % 3)
                0: rv = 0;
                1: rv = 32'hFFFF_FFFF;
                default: rv = $urandom_range(0, 32'h20000);
            endcase
            write_reg(CFG_MIN_EXPOSURE, rv);
            case (p % 4)
                0: rv = 255;
                1: rv = 0;
                2: rv = 1;
                default: rv = $urandom_range(2, 9);
            endcase
            write_reg(CFG_BASE_PERIOD, rv);
            for (int i = 0; i < 240; i++) send_frame(rand_frame());
            drain();
        end

        repeat (50) @(negedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ae_pkg.sv
rtl/ae_div.sv
rtl/ae_dp.sv
rtl/ae_ctrl.sv
rtl/auto_exposure_adapter_top.sv
sim/tb_auto_exposure_adapter_top.sv
